// File: design/rssi_proximity_lock_controller_macros.svh
// assertion macros for the controller's checks
`ifndef RSSI_PROXIMITY_LOCK_CONTROLLER_MACROS_SVH
`define RSSI_PROXIMITY_LOCK_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled in reset
`define RPLC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rplc check failed");

// next-cycle implication, disabled in reset
`define RPLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rplc check failed");

`endif

// File: design/rplc_pkg.sv
// ----------------------------------------------------------------------------
// rplc_pkg
// shared constants and codes for the rssi proximity lock controller
// ----------------------------------------------------------------------------
package rplc_pkg;

  // input kinds (tuser)
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_MANUAL = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // manual commands
  localparam logic [1:0] CMD_OTHER  = 2'd0;
  localparam logic [1:0] CMD_UNLOCK = 2'd1;
  localparam logic [1:0] CMD_LOCK   = 2'd2;
  localparam logic [1:0] CMD_TRUNK  = 2'd3;

  // door states
  localparam logic [1:0] DOOR_LOCKED   = 2'd0;
  localparam logic [1:0] DOOR_UNLOCKED = 2'd1;
  localparam logic [1:0] DOOR_UNKNOWN  = 2'd2;

  // pin masks
  localparam logic [2:0] PIN_UNLOCK = 3'b001;
  localparam logic [2:0] PIN_LOCK   = 3'b010;
  localparam logic [2:0] PIN_TRUNK  = 3'b100;

  // register indexes
  localparam logic [2:0] CFG_UNLOCK_THR  = 3'd0;
  localparam logic [2:0] CFG_LOCK_THR    = 3'd1;
  localparam logic [2:0] CFG_UNLOCK_RUNS = 3'd2;
  localparam logic [2:0] CFG_LOCK_RUNS   = 3'd3;
  localparam logic [2:0] CFG_COOLDOWN    = 3'd4;
  localparam logic [2:0] CFG_NOISE_R     = 3'd5;
  localparam logic [2:0] CFG_LOCK_PULSE  = 3'd6;
  localparam logic [2:0] CFG_TRUNK_PULSE = 3'd7;

  localparam logic [1:0]        SPIKE_LIMIT = 2'd2;
  localparam logic signed [8:0] SPIKE_JUMP  = 9'sd25;
  localparam logic [15:0]       Q_ONE       = 16'd256;
  localparam logic signed [15:0] EST_RESET  = -16'sd20480;

  // divider geometry
  localparam int DIV_NUM_W  = 34;
  localparam int DIV_DEN_W  = 18;
  localparam int DIV_QUOT_W = 17;

endpackage

// File: design/rplc_div.sv
// ----------------------------------------------------------------------------
// rplc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rplc_div #(
  parameter int NUM_W  = 34,
  parameter int DEN_W  = 18,
  parameter int QUOT_W = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  // quotient is known to fit QUOT_W bits, so the top of num is below den
  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [QUOT_W-1:0] low;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign trial = {rem, low[QUOT_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};
  assign quot  = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(QUOT_W);
        rem   <= DEN_W'(num[NUM_W-1:QUOT_W]);
        low   <= num[QUOT_W-1:0];
        den_r <= den;
      end else if (busy) begin
        rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low <= {low[QUOT_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/rssi_proximity_lock_controller.sv
// sequencing: ticks, commands, resets and filtered-out samples go from idle
//   to the emit state, then into the output register; a filter update first
//   runs MULX, DIVX, MULP and DIVP, two 17-step passes through the shared divider
// flow: only one transaction is in flight at a time; a new one is accepted
//   only while idle and while the output register is free or being taken
// reset: rst is synchronous, active high; registers return to their defaults,
//   door state goes to unknown, the estimate to -80 dBm
// ----------------------------------------------------------------------------
// rssi_proximity_lock_controller
// scalar kalman filter on rssi with hysteresis lock / unlock decisions
// ----------------------------------------------------------------------------
module rssi_proximity_lock_controller #(
  parameter int DIV_NUM_W  = rplc_pkg::DIV_NUM_W,
  parameter int DIV_DEN_W  = rplc_pkg::DIV_DEN_W,
  parameter int DIV_QUOT_W = rplc_pkg::DIV_QUOT_W
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // rssi[7:0], command[9:8], zero fill
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // key_state[1:0], pins[4:2], estimate[20:5], estimate_valid[21],
  // latest_rssi[29:22], cooling[30], zero fill
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MULX = 6'b000010,
    ST_DIVX = 6'b000100,
    ST_MULP = 6'b001000,
    ST_DIVP = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic signed [7:0] unlock_threshold, lock_threshold;
  logic [4:0]        unlock_runs, lock_runs;
  logic [14:0]       cooldown_limit;
  logic [5:0]        noise_r;
  logic [15:0]       lock_pulse_ms, trunk_pulse_ms;

  // controller state
  logic signed [15:0] est_value, est_value_next;
  logic [15:0]        est_variance, est_variance_next;
  logic               filter_started, filter_started_next;
  logic signed [7:0]  prev_raw, prev_raw_next;
  logic               prev_raw_valid, prev_raw_valid_next;
  logic signed [7:0]  last_accepted, last_accepted_next;
  logic [1:0]         spike_run, spike_run_next;
  logic               new_estimate, new_estimate_next;
  logic [4:0]         near_run, near_run_next;
  logic [4:0]         far_run, far_run_next;
  logic [1:0]         door_state, door_state_next;
  logic [2:0]         pulse_pins, pulse_pins_next;
  logic [15:0]        pulse_left, pulse_left_next;
  logic               cooldown_on, cooldown_on_next;
  logic [14:0]        cooldown_elapsed, cooldown_elapsed_next;

  // filter update operands, latched when a sample is taken
  logic               k_neg, k_neg_next;
  logic [16:0]        k_mag, k_mag_next;
  logic [16:0]        k_pp, k_pp_next;
  logic [17:0]        k_den, k_den_next;

  // divider hookup
  logic                  div_start;
  logic [DIV_NUM_W-1:0]  div_num;
  logic                  div_done;
  logic [DIV_QUOT_W-1:0] div_quot;

  // input fields
  logic                in_acc;
  logic [1:0]          in_op;
  logic signed [7:0]   in_rssi;
  logic [1:0]          in_cmd;

  // helpers
  logic signed [8:0]   jump;
  logic signed [16:0]  meas_diff;
  logic                tick_go;
  logic [33:0]         prod_x;
  logic [22:0]         prod_p;
  logic signed [17:0]  est_sum;

  assign in_op   = s_axis_tuser;
  assign in_rssi = s_axis_tdata[7:0];
  assign in_cmd  = s_axis_tdata[9:8];
  assign s_axis_tready = (state == ST_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign jump      = 9'(in_rssi) - 9'(prev_raw);
  assign meas_diff = 17'($signed({in_rssi, 8'h00})) - 17'(est_value);
  assign prod_x    = k_mag * k_pp;
  assign prod_p    = 23'(k_pp) * 23'(noise_r);
  // apply the rounded step with its sign
  assign est_sum   = k_neg ? 18'(est_value) - 18'(div_quot)
                           : 18'(est_value) + 18'(div_quot);

  rplc_div #(
    .NUM_W  (DIV_NUM_W),
    .DEN_W  (DIV_DEN_W),
    .QUOT_W (DIV_QUOT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (DIV_DEN_W'(k_den)),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_next            = state;
    est_value_next        = est_value;
    est_variance_next     = est_variance;
    filter_started_next   = filter_started;
    prev_raw_next         = prev_raw;
    prev_raw_valid_next   = prev_raw_valid;
    last_accepted_next    = last_accepted;
    spike_run_next        = spike_run;
    new_estimate_next     = new_estimate;
    near_run_next         = near_run;
    far_run_next          = far_run;
    door_state_next       = door_state;
    pulse_pins_next       = pulse_pins;
    pulse_left_next       = pulse_left;
    cooldown_on_next      = cooldown_on;
    cooldown_elapsed_next = cooldown_elapsed;
    k_neg_next            = k_neg;
    k_mag_next            = k_mag;
    k_pp_next             = k_pp;
    k_den_next            = k_den;
    tick_go               = 1'b1;

    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_EMIT;
          case (in_op)
            rplc_pkg::OP_SAMPLE: begin
              // non-negative samples are dropped entirely
              if (in_rssi[7]) begin
                last_accepted_next = in_rssi;
                if (prev_raw_valid) begin
                  if (jump > rplc_pkg::SPIKE_JUMP || jump < -rplc_pkg::SPIKE_JUMP) begin
                    if (spike_run != 2'd3) spike_run_next = spike_run + 2'd1;
                  end else begin
                    spike_run_next = 2'd0;
                  end
                end
                prev_raw_next       = in_rssi;
                prev_raw_valid_next = 1'b1;
                if (spike_run_next < rplc_pkg::SPIKE_LIMIT) begin
                  new_estimate_next = 1'b1;
                  if (!filter_started) begin
                    // first sample seeds the estimate
                    est_value_next      = {in_rssi, 8'h00};
                    filter_started_next = 1'b1;
                  end else begin
                    k_neg_next = meas_diff[16];
                    k_mag_next = meas_diff[16] ? 17'(-meas_diff) : 17'(meas_diff);
                    k_pp_next  = 17'(est_variance) + 17'(rplc_pkg::Q_ONE);
                    k_den_next = 18'(est_variance) + 18'(rplc_pkg::Q_ONE)
                               + 18'({noise_r, 8'h00});
                    state_next = ST_MULX;
                  end
                end
              end
            end
            rplc_pkg::OP_TICK: begin
              // pulse countdown first
              if (pulse_pins != 3'd0) begin
                if (pulse_left <= 16'd1) begin
                  pulse_left_next = 16'd0;
                  pulse_pins_next = 3'd0;
                end else begin
                  pulse_left_next = pulse_left - 16'd1;
                end
              end
              // then the manual cooldown
              if (cooldown_on) begin
                if (cooldown_elapsed != 15'h7FFF)
                  cooldown_elapsed_next = cooldown_elapsed + 15'd1;
                if (cooldown_elapsed_next >= cooldown_limit) cooldown_on_next = 1'b0;
                else tick_go = 1'b0;
              end
              // then the run decision on the newest estimate
              if (tick_go && filter_started && pulse_pins_next == 3'd0 && new_estimate) begin
                new_estimate_next = 1'b0;
                if (est_value > $signed({unlock_threshold, 8'h00})) begin
                  if (near_run != 5'd31) near_run_next = near_run + 5'd1;
                  far_run_next = 5'd0;
                  if (near_run_next >= unlock_runs &&
                      door_state != rplc_pkg::DOOR_UNLOCKED) begin
                    door_state_next = rplc_pkg::DOOR_UNLOCKED;
                    near_run_next   = 5'd0;
                    pulse_pins_next = rplc_pkg::PIN_UNLOCK;
                    pulse_left_next = lock_pulse_ms;
                  end
                end else if (est_value < $signed({lock_threshold, 8'h00})) begin
                  if (far_run != 5'd31) far_run_next = far_run + 5'd1;
                  near_run_next = 5'd0;
                  if (far_run_next >= lock_runs &&
                      door_state != rplc_pkg::DOOR_LOCKED) begin
                    door_state_next = rplc_pkg::DOOR_LOCKED;
                    far_run_next    = 5'd0;
                    pulse_pins_next = rplc_pkg::PIN_LOCK;
                    pulse_left_next = lock_pulse_ms;
                  end
                end else begin
                  near_run_next = 5'd0;
                  far_run_next  = 5'd0;
                end
              end
            end
            rplc_pkg::OP_MANUAL: begin
              cooldown_on_next      = 1'b1;
              cooldown_elapsed_next = 15'd0;
              case (in_cmd)
                rplc_pkg::CMD_TRUNK: begin
                  if (pulse_pins == 3'd0) begin
                    pulse_pins_next = rplc_pkg::PIN_TRUNK;
                    pulse_left_next = trunk_pulse_ms;
                  end
                end
                rplc_pkg::CMD_UNLOCK: begin
                  door_state_next = rplc_pkg::DOOR_UNLOCKED;
                  near_run_next   = 5'd0;
                  far_run_next    = 5'd0;
                  if (pulse_pins == 3'd0) begin
                    pulse_pins_next = rplc_pkg::PIN_UNLOCK;
                    pulse_left_next = lock_pulse_ms;
                  end
                end
                rplc_pkg::CMD_LOCK: begin
                  door_state_next = rplc_pkg::DOOR_LOCKED;
                  near_run_next   = 5'd0;
                  far_run_next    = 5'd0;
                  if (pulse_pins == 3'd0) begin
                    pulse_pins_next = rplc_pkg::PIN_LOCK;
                    pulse_left_next = lock_pulse_ms;
                  end
                end
                default: ;
              endcase
            end
            default: begin
              // session reset keeps door state and registers
              est_value_next        = rplc_pkg::EST_RESET;
              est_variance_next     = rplc_pkg::Q_ONE;
              filter_started_next   = 1'b0;
              prev_raw_next         = 8'sd0;
              prev_raw_valid_next   = 1'b0;
              last_accepted_next    = 8'sd0;
              spike_run_next        = 2'd0;
              new_estimate_next     = 1'b0;
              near_run_next         = 5'd0;
              far_run_next          = 5'd0;
              pulse_pins_next       = 3'd0;
              pulse_left_next       = 16'd0;
              cooldown_on_next      = 1'b0;
              cooldown_elapsed_next = 15'd0;
            end
          endcase
        end
      end
      ST_MULX: state_next = ST_DIVX;
      ST_DIVX: begin
        if (div_done) begin
          // clamp to [-32768, 0]
          if (est_sum < -18'sd32768)   est_value_next = -16'sd32768;
          else if (est_sum > 18'sd0)   est_value_next = 16'sd0;
          else                         est_value_next = est_sum[15:0];
          state_next = ST_MULP;
        end
      end
      ST_MULP: state_next = ST_DIVP;
      ST_DIVP: begin
        if (div_done) begin
          est_variance_next = div_quot[15:0];
          state_next        = ST_EMIT;
        end
      end
      ST_EMIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      unlock_threshold <= -8'sd45;
      lock_threshold   <= -8'sd65;
      unlock_runs      <= 5'd3;
      lock_runs        <= 5'd5;
      cooldown_limit   <= 15'd8000;
      noise_r          <= 6'd25;
      lock_pulse_ms    <= 16'd200;
      trunk_pulse_ms   <= 16'd1000;
      est_value        <= rplc_pkg::EST_RESET;
      est_variance     <= rplc_pkg::Q_ONE;
      filter_started   <= 1'b0;
      prev_raw         <= 8'sd0;
      prev_raw_valid   <= 1'b0;
      last_accepted    <= 8'sd0;
      spike_run        <= 2'd0;
      new_estimate     <= 1'b0;
      near_run         <= 5'd0;
      far_run          <= 5'd0;
      door_state       <= rplc_pkg::DOOR_UNKNOWN;
      pulse_pins       <= 3'd0;
      pulse_left       <= 16'd0;
      cooldown_on      <= 1'b0;
      cooldown_elapsed <= 15'd0;
      div_start        <= 1'b0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      state            <= state_next;
      est_value        <= est_value_next;
      est_variance     <= est_variance_next;
      filter_started   <= filter_started_next;
      prev_raw         <= prev_raw_next;
      prev_raw_valid   <= prev_raw_valid_next;
      last_accepted    <= last_accepted_next;
      spike_run        <= spike_run_next;
      new_estimate     <= new_estimate_next;
      near_run         <= near_run_next;
      far_run          <= far_run_next;
      door_state       <= door_state_next;
      pulse_pins       <= pulse_pins_next;
      pulse_left       <= pulse_left_next;
      cooldown_on      <= cooldown_on_next;
      cooldown_elapsed <= cooldown_elapsed_next;
      div_start        <= (state == ST_MULX) || (state == ST_MULP);

      if (cfg_we) begin
        case (cfg_index)
          rplc_pkg::CFG_UNLOCK_THR:  unlock_threshold <= cfg_data[7:0];
          rplc_pkg::CFG_LOCK_THR:    lock_threshold   <= cfg_data[7:0];
          rplc_pkg::CFG_UNLOCK_RUNS: unlock_runs      <= cfg_data[4:0];
          rplc_pkg::CFG_LOCK_RUNS:   lock_runs        <= cfg_data[4:0];
          rplc_pkg::CFG_COOLDOWN:    cooldown_limit   <= cfg_data[14:0];
          rplc_pkg::CFG_NOISE_R:     noise_r          <= cfg_data[5:0];
          rplc_pkg::CFG_LOCK_PULSE:  lock_pulse_ms    <= cfg_data;
          rplc_pkg::CFG_TRUNK_PULSE: trunk_pulse_ms   <= cfg_data;
          default: ;
        endcase
      end

      // output register: loaded once the transaction is fully worked
      if (state == ST_EMIT) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    k_neg <= k_neg_next;
    k_mag <= k_mag_next;
    k_pp  <= k_pp_next;
    k_den <= k_den_next;
    // gain step numerator, then variance numerator, both rounded by den/2
    if (state == ST_MULX)
      div_num <= DIV_NUM_W'(prod_x) + DIV_NUM_W'(k_den >> 1);
    else if (state == ST_MULP)
      div_num <= DIV_NUM_W'({prod_p, 8'h00}) + DIV_NUM_W'(k_den >> 1);
    if (state == ST_EMIT)
      m_axis_tdata <= {1'b0, cooldown_on, last_accepted, filter_started,
                       est_value, pulse_pins, door_state};
  end

  `include "rssi_proximity_lock_controller_macros.svh"

  // items only enter while the sequencer is idle
  `RPLC_ASSERT_IMPL(a_accept_idle, in_acc, state == ST_IDLE)
  // the divider only finishes while the sequencer waits on it
  `RPLC_ASSERT_IMPL(a_div_owned, div_done, state == ST_DIVX || state == ST_DIVP)
  // at most one output pin is driven
  `RPLC_ASSERT_IMPL(a_one_pin, 1'b1, $onehot0(pulse_pins))
  // the estimate never goes above zero dBm
  `RPLC_ASSERT_IMPL(a_est_range, 1'b1, est_value[15] || est_value == 16'sd0)
  // a worked transaction always lands in the output register
  `RPLC_ASSERT_NEXT(a_emit_valid, state == ST_EMIT, m_axis_tvalid)

endmodule

// File: test/rssi_proximity_lock_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rssi_proximity_lock_controller_tb
// self-checking bench: drives rssi samples, ticks, manual commands and
// session resets with random gaps and backpressure, predicts every result
// transaction in a scoreboard and compares it field by field
// ----------------------------------------------------------------------------
module rssi_proximity_lock_controller_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD = 300;

  // one result transaction split into its fields
  typedef struct {
    logic [1:0]         key_state;
    logic [2:0]         pins;
    logic signed [15:0] estimate;
    logic               estimate_valid;
    logic signed [7:0]  latest_rssi;
    logic               cooling;
  } lock_status_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of filter, run and pulse state plus the registers
  // --------------------------------------------------------------------------
  class lock_scoreboard;
    int unlock_thr, lock_thr;
    int unsigned unlock_len, lock_len, cool_len, noise_r, lock_pulse, trunk_pulse;
    int est_x;
    int unsigned est_p;
    bit started, prev_valid, fresh, cool_on;
    int prev_raw, last_acc;
    int unsigned spikes, near_cnt, far_cnt, cool_cnt, pulse_cnt;
    logic [1:0] door;
    logic [2:0] pulse_pins;
    lock_status_t status_q[$];
    int mismatches;

    function new();
      unlock_thr = -45; lock_thr = -65; unlock_len = 3; lock_len = 5;
      cool_len = 8000; noise_r = 25; lock_pulse = 200; trunk_pulse = 1000;
      door = rplc_pkg::DOOR_UNKNOWN;
      mismatches = 0;
      clear_session();
    endfunction

    function void clear_session();
      est_x = -80 * 256; est_p = 256;
      started = 0; prev_valid = 0; fresh = 0; cool_on = 0;
      prev_raw = 0; last_acc = 0;
      spikes = 0; near_cnt = 0; far_cnt = 0; cool_cnt = 0; pulse_cnt = 0;
      pulse_pins = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        rplc_pkg::CFG_UNLOCK_THR:  unlock_thr = int'($signed(v[7:0]));
        rplc_pkg::CFG_LOCK_THR:    lock_thr = int'($signed(v[7:0]));
        rplc_pkg::CFG_UNLOCK_RUNS: unlock_len = v[4:0];
        rplc_pkg::CFG_LOCK_RUNS:   lock_len = v[4:0];
        rplc_pkg::CFG_COOLDOWN:    cool_len = v[14:0];
        rplc_pkg::CFG_NOISE_R:     noise_r = v[5:0];
        rplc_pkg::CFG_LOCK_PULSE:  lock_pulse = v;
        rplc_pkg::CFG_TRUNK_PULSE: trunk_pulse = v;
        default: ;
      endcase
    endfunction

    // a pulse already running wins
    function void fire(logic [2:0] pin, int unsigned len);
      if (pulse_pins == '0) begin
        pulse_pins = pin;
        pulse_cnt = len;
      end
    endfunction

    function void filter_update(int m);
      longint meas, diff, mag, pp, d, delta, x;
      meas = longint'(m) * 256;
      if (!started) begin
        est_x = int'(meas);
        started = 1;
        return;
      end
      pp = longint'(est_p) + 256;
      d = pp + longint'(noise_r) * 256;
      diff = meas - est_x;
      mag = (diff < 0) ? -diff : diff;
      delta = (mag * pp + d / 2) / d;
      x = (diff < 0) ? est_x - delta : est_x + delta;
      if (x < -32768) x = -32768;
      if (x > 0) x = 0;
      est_x = int'(x);
      est_p = int'((pp * noise_r * 256 + d / 2) / d);
    endfunction

    function void take_sample(int r);
      int jump;
      if (r >= 0) return;  // non-negative readings are dropped
      last_acc = r;
      if (prev_valid) begin
        jump = r - prev_raw;
        if (jump > 25 || jump < -25) begin
          if (spikes < 3) spikes++;
        end else begin
          spikes = 0;
        end
      end
      prev_raw = r;
      prev_valid = 1;
      if (spikes < rplc_pkg::SPIKE_LIMIT) begin
        filter_update(r);
        fresh = 1;
      end
    endfunction

    // pulse countdown, then cooldown, then run decision
    function void ms_tick();
      if (pulse_pins != '0) begin
        if (pulse_cnt <= 1) begin
          pulse_cnt = 0;
          pulse_pins = '0;
        end else begin
          pulse_cnt--;
        end
      end
      if (cool_on) begin
        if (cool_cnt < 32767) cool_cnt++;
        if (cool_cnt >= cool_len) cool_on = 0;
        else return;
      end
      if (!started || pulse_pins != '0 || !fresh) return;
      fresh = 0;
      if (est_x > unlock_thr * 256) begin
        if (near_cnt < 31) near_cnt++;
        far_cnt = 0;
        if (near_cnt >= unlock_len && door != rplc_pkg::DOOR_UNLOCKED) begin
          door = rplc_pkg::DOOR_UNLOCKED;
          near_cnt = 0;
          fire(rplc_pkg::PIN_UNLOCK, lock_pulse);
        end
      end else if (est_x < lock_thr * 256) begin
        if (far_cnt < 31) far_cnt++;
        near_cnt = 0;
        if (far_cnt >= lock_len && door != rplc_pkg::DOOR_LOCKED) begin
          door = rplc_pkg::DOOR_LOCKED;
          far_cnt = 0;
          fire(rplc_pkg::PIN_LOCK, lock_pulse);
        end
      end else begin
        near_cnt = 0;
        far_cnt = 0;
      end
    endfunction

    function void manual_cmd(logic [1:0] cmd);
      cool_on = 1;
      cool_cnt = 0;
      case (cmd)
        rplc_pkg::CMD_TRUNK: fire(rplc_pkg::PIN_TRUNK, trunk_pulse);
        rplc_pkg::CMD_UNLOCK: begin
          door = rplc_pkg::DOOR_UNLOCKED; near_cnt = 0; far_cnt = 0;
          fire(rplc_pkg::PIN_UNLOCK, lock_pulse);
        end
        rplc_pkg::CMD_LOCK: begin
          door = rplc_pkg::DOOR_LOCKED; near_cnt = 0; far_cnt = 0;
          fire(rplc_pkg::PIN_LOCK, lock_pulse);
        end
        default: ;
      endcase
    endfunction

    // accepted input transaction: advance state, queue the expected status
    function void note_input(logic [1:0] op, logic [7:0] rssi, logic [1:0] cmd);
      lock_status_t s;
      case (op)
        rplc_pkg::OP_SAMPLE: take_sample(int'($signed(rssi)));
        rplc_pkg::OP_TICK:   ms_tick();
        rplc_pkg::OP_MANUAL: manual_cmd(cmd);
        default:             clear_session();
      endcase
      s.key_state = door;
      s.pins = pulse_pins;
      s.estimate = est_x[15:0];
      s.estimate_valid = started;
      s.latest_rssi = last_acc[7:0];
      s.cooling = cool_on;
      status_q.push_back(s);
    endfunction

    function void check_result(logic [31:0] data);
      lock_status_t e, a;
      a.key_state = data[1:0];
      a.pins = data[4:2];
      a.estimate = data[20:5];
      a.estimate_valid = data[21];
      a.latest_rssi = data[29:22];
      a.cooling = data[30];
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", data);
        return;
      end
      e = status_q.pop_front();
      if (a.key_state !== e.key_state || a.pins !== e.pins ||
          a.estimate !== e.estimate || a.estimate_valid !== e.estimate_valid ||
          a.latest_rssi !== e.latest_rssi || a.cooling !== e.cooling) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp key %0d pins %b est %0d vld %b rssi %0d cool %b",
                    " | got key %0d pins %b est %0d vld %b rssi %0d cool %b"},
                   e.key_state, e.pins, e.estimate, e.estimate_valid,
                   e.latest_rssi, e.cooling,
                   a.key_state, a.pins, a.estimate, a.estimate_valid,
                   a.latest_rssi, a.cooling);
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // dut hookup
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // rssi[7:0], command[9:8], zero fill
  logic [1:0]  s_axis_tuser = '0;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // key_state[1:0], pins[4:2], estimate[20:5], estimate_valid[21],
  // latest_rssi[29:22], cooling[30], zero fill
  logic [31:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  rssi_proximity_lock_controller u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  lock_scoreboard sb = new();

  bit tx_burst = 0;   // sender offers back to back
  bit rx_burst = 0;   // receiver without per-transaction stalls
  bit hold_req = 0;   // ask the receiver for one long hold-off
  int rx_wait = 0;
  int hold_left = 0;
  int cycles = 0;
  int level = -60;    // where the simulated key fob currently sits, dBm

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** rssi_proximity_lock_controller: FAILED **");
      $finish;
    end
  end

  // result monitor: every accepted result transaction goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
      rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
    end
  end

  // receiver ready, with per-transaction stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (rx_wait > 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // one input transaction; called and returns at a falling edge
  task automatic send_item(logic [1:0] op, logic [7:0] rssi, logic [1:0] cmd);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, cmd, rssi};
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, rssi, cmd);
    @(negedge clk);
  endtask

  task automatic send_sample(int r);
    send_item(rplc_pkg::OP_SAMPLE, r[7:0], 2'($urandom));
  endtask

  // ignored data fields still toggle
  task automatic send_op(logic [1:0] op, logic [1:0] cmd);
    send_item(op, 8'($urandom), cmd);
  endtask

  task automatic tick_burst(int n);
    repeat (n) send_op(rplc_pkg::OP_TICK, 2'($urandom));
  endtask

  // let everything in flight come out before touching registers
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // cfg_we stays high across back-to-back writes; caller lowers it
  task automatic cfg_write(logic [2:0] idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic load_setting(int uthr, int lthr, int urun, int lrun,
                              int cool, int nr, int lp, int tp);
    cfg_write(rplc_pkg::CFG_UNLOCK_THR, 16'(uthr[7:0]));
    cfg_write(rplc_pkg::CFG_LOCK_THR, 16'(lthr[7:0]));
    cfg_write(rplc_pkg::CFG_UNLOCK_RUNS, 16'(urun));
    cfg_write(rplc_pkg::CFG_LOCK_RUNS, 16'(lrun));
    cfg_write(rplc_pkg::CFG_COOLDOWN, 16'(cool));
    cfg_write(rplc_pkg::CFG_NOISE_R, 16'(nr));
    cfg_write(rplc_pkg::CFG_LOCK_PULSE, 16'(lp));
    cfg_write(rplc_pkg::CFG_TRUNK_PULSE, 16'(tp));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // samples from a slowly wandering fob with jitter, plus spikes and junk, mixed with ticks, commands and resets
  task automatic random_item();
    int pick, kind, r;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) level = -$urandom_range(20, 100);
      else level = level + $urandom_range(0, 4) - 2;
      if (level > -10) level = -10;
      if (level < -110) level = -110;
      if (kind < 82) r = level + $urandom_range(0, 6) - 3;
      else if (kind < 90) r = level + (($urandom_range(0, 1) != 0) ? 1 : -1) *
                              $urandom_range(26, 60);
      else if (kind < 95) r = $urandom_range(0, 127);
      else r = -$urandom_range(1, 128);
      if (r > 127) r = 127;
      if (r < -128) r = -128;
      send_sample(r);
    end else if (pick < 88) begin
      send_op(rplc_pkg::OP_TICK, 2'($urandom));
    end else if (pick < 91) begin
      send_op(rplc_pkg::OP_MANUAL, 2'($urandom));
    end else if (pick < 94) begin
      send_op(rplc_pkg::OP_CLEAR, 2'($urandom));
    end else begin
      tick_burst($urandom_range(3, 12));
    end
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      random_item();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: first sample at the floor, ignored readings, spikes,
    // every command, session reset, reset-value registers
    send_sample(-128);
    send_sample(0);
    send_sample(127);
    send_sample(-1);
    send_sample(-60);
    send_sample(-30);     // third spike in a row, update suppressed
    send_sample(-90);     // fourth spike in a row, update suppressed
    send_sample(-88);
    send_sample(-40);
    tick_burst(3);
    send_op(rplc_pkg::OP_MANUAL, rplc_pkg::CMD_UNLOCK);
    send_op(rplc_pkg::OP_MANUAL, rplc_pkg::CMD_LOCK);     // pulse busy, state still moves
    send_op(rplc_pkg::OP_MANUAL, rplc_pkg::CMD_TRUNK);
    send_op(rplc_pkg::OP_MANUAL, rplc_pkg::CMD_OTHER);
    tick_burst(3);
    send_op(rplc_pkg::OP_CLEAR, rplc_pkg::CMD_OTHER);
    send_sample(-50);
    send_sample(-45);
    tick_burst(2);

    // defaults, with the long receiver hold-off while the sender keeps going
    @(posedge clk);
    hold_req = 1;
    @(negedge clk);
    random_phase(50);

    // fastest decisions, short cooldown; let one cooldown run out
    drain();
    load_setting(-45, -65, 1, 1, 12, 1, 1, 3);
    random_phase(45);
    send_op(rplc_pkg::OP_MANUAL, rplc_pkg::CMD_OTHER);
    tick_burst(15);
    random_phase(30);

    // large runs, cooldown and noise, zero pulse lengths
    drain();
    load_setting(-1, -100, 30, 30, 30000, 50, 0, 0);
    random_phase(50);

    // crossed thresholds, zero runs and zero noise, longest trunk pulse
    drain();
    load_setting(-100, -1, 0, 0, 8, 0, 2, 65535);
    random_phase(40);

    // middle setting, maximum lock pulse
    drain();
    load_setting(-60, -70, 2, 3, 20, 10, 65535, 5);
    random_phase(25);
    drain();
    load_setting(-55, -75, 2, 3, 10, 10, 4, 5);
    random_phase(55);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** rssi_proximity_lock_controller: PASSED **");
    end else begin
      $display("** rssi_proximity_lock_controller: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/rplc_pkg.sv
design/rplc_div.sv
design/rssi_proximity_lock_controller.sv
test/rssi_proximity_lock_controller_tb.sv
